FILE: rtl/lsms_pkg.sv
// Shared opcodes, field types and fixed port widths of the load/store step unit.
package lsms_pkg;

    localparam int OP_BITS      = 4;
    localparam int REG_IDX_BITS = 5;
    localparam int IMM_BITS     = 32;
    localparam int RESULT_BITS  = 32;

    typedef logic [OP_BITS-1:0]      t_opcode;
    typedef logic [REG_IDX_BITS-1:0] t_reg_idx;

    // Codes above OP_MOVE, the nop code among them, do nothing and return rc.
    localparam t_opcode OP_ADD   = 4'd0;
    localparam t_opcode OP_SUB   = 4'd1;
    localparam t_opcode OP_AND   = 4'd2;
    localparam t_opcode OP_OR    = 4'd3;
    localparam t_opcode OP_CMP   = 4'd4;
    localparam t_opcode OP_LOAD  = 4'd5;
    localparam t_opcode OP_STORE = 4'd6;
    localparam t_opcode OP_MOVE  = 4'd7;

endpackage

FILE: rtl/load_store_machine_step_unit.sv
// Top level of the load/store step unit: register file, data memory and sequencer.
//
// Usage: raise start with one instruction on i_operation, i_first_reg (ra),
// i_second_reg (rb), i_dest_reg (rc) and i_immediate; the request is taken at a
// clock edge where start is high and busy is low. Each request returns one word
// on o_result_word, shown for exactly one cycle while o_done is high. The
// receiver cannot stall, so the result is simply dropped if nobody samples it.
//
// Sequence: an accepted request enters the execute state. ALU ops, move, nop
// and store show their result after it; a load passes on to the load state,
// which returns the data memory read, and shows its result after that.
// busy falls in the cycle that shows the result, so a new request can be taken
// there. The two register reads happen at the accepting edge and the writeback
// at the last busy edge, so the register file never sees a read and a write to
// one entry at once. Non-power-of-two MEM_WORDS: loads and stores also pass
// the reduction state, an estimate and a correct phase per 16-bit slice of rb.
//
// Reset: registers read as zero through per-entry valid bits, cleared at once.
// The data memory is swept to zero after reset, one word per cycle, over all
// MEM_WORDS words; busy stays high until the sweep ends.
module load_store_machine_step_unit #(
    parameter int REG_COUNT = 32,
    parameter int MEM_WORDS = 1024,
    parameter int WORD_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    input  lsms_pkg::t_opcode                  i_operation,
    input  lsms_pkg::t_reg_idx                 i_first_reg,
    input  lsms_pkg::t_reg_idx                 i_second_reg,
    input  lsms_pkg::t_reg_idx                 i_dest_reg,
    input  logic [lsms_pkg::IMM_BITS-1:0]      i_immediate,
    output logic                               busy,
    output logic                               o_done,
    output logic [lsms_pkg::RESULT_BITS-1:0]   o_result_word
);
    import lsms_pkg::*;

    localparam int RF_AW      = $clog2(REG_COUNT);
    localparam int DM_AW      = $clog2(MEM_WORDS);
    localparam int CHUNK_BITS = 16;
    localparam int N_CHUNKS   = (WORD_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int SRC_BITS   = N_CHUNKS * CHUNK_BITS;
    localparam int CNT_W      = $clog2(N_CHUNKS + 1);
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(MEM_WORDS));
    localparam bit MEM_POW2   = ((MEM_WORDS & (MEM_WORDS - 1)) == 0);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_EXEC  = 5'b00100,
        S_MOD   = 5'b01000,
        S_LOAD  = 5'b10000
    } t_state;

    // Register index is usable: not register zero and inside the bank.
    function automatic logic reg_ok(input t_reg_idx idx);
        return (idx != '0) && (int'(idx) < REG_COUNT);
    endfunction

    function automatic logic [RF_AW-1:0] rf_idx(input t_reg_idx idx);
        return RF_AW'(idx);
    endfunction

    // Storage
    logic [WORD_BITS-1:0] rf   [REG_COUNT];
    logic [WORD_BITS-1:0] dmem [MEM_WORDS];
    logic [REG_COUNT-1:0] r_rf_valid;

    // Control
    t_state               r_state, n_state;
    logic [DM_AW-1:0]     r_clr_addr;
    logic                 r_done, n_done;

    // Request and operand holding
    t_opcode              r_op;
    t_reg_idx             r_ra, r_rc;
    logic [WORD_BITS-1:0] r_imm;
    logic [WORD_BITS-1:0] r_rd_a, r_rd_b;
    logic                 r_a_zero, r_b_zero;
    logic [WORD_BITS-1:0] r_mem_rd;
    logic [RESULT_BITS-1:0] r_result, n_result;

    // Address reduction
    logic [DM_AW-1:0]     r_rem;
    logic [SRC_BITS-1:0]  r_div_src;
    logic [CNT_W-1:0]     r_mod_cnt;
    logic                 r_mod_ph;
    logic [31:0]          r_quo;

    logic                 accept;
    t_reg_idx             rd_idx_a;
    logic [WORD_BITS-1:0] op_a, op_b, alu_val, res_word;
    logic [63:0]          res_wide;
    logic                 is_ldst, mem_go, mod_last;
    logic [DM_AW-1:0]     dm_addr, dm_wa;
    logic                 dm_we;
    logic [WORD_BITS-1:0] dm_wd;
    logic [31:0]          mod_y;
    logic [63:0]          quo_wide, sub_w;
    logic [DM_AW:0]       rem_sh, rem_nx_w;
    logic [DM_AW-1:0]     rem_nx;
    logic                 rf_we;
    t_reg_idx             rf_wa;
    logic [WORD_BITS-1:0] rf_wd;

    assign busy          = (r_state != S_IDLE);
    assign accept        = start && !busy;
    assign o_done        = r_done;
    assign o_result_word = r_result;

    // Nop-class codes return rc, so read rc on port A in place of ra.
    assign rd_idx_a = (i_operation > OP_MOVE) ? i_dest_reg : i_first_reg;

    assign op_a    = r_a_zero ? '0 : r_rd_a;
    assign op_b    = r_b_zero ? '0 : r_rd_b;
    assign is_ldst = (r_op == OP_LOAD) || (r_op == OP_STORE);

    // Reduce rb mod MEM_WORDS one 16-bit slice at a time, MSB first. Phase 0
    // estimates the quotient by a reciprocal multiply (low by at most one),
    // phase 1 subtracts it and corrects once.
    assign mod_y    = {CHUNK_BITS'(r_rem), r_div_src[SRC_BITS-1 -: CHUNK_BITS]};
    assign quo_wide = 64'(mod_y) * 64'(RECIP);
    assign sub_w    = 64'(mod_y) - (64'(r_quo) * 64'(MEM_WORDS));
    assign rem_sh   = sub_w[DM_AW:0];
    assign rem_nx_w = (rem_sh >= (DM_AW+1)'(MEM_WORDS)) ?
                      (rem_sh - (DM_AW+1)'(MEM_WORDS)) : rem_sh;
    assign rem_nx   = rem_nx_w[DM_AW-1:0];

    assign mod_last = (r_state == S_MOD) && r_mod_ph && (r_mod_cnt == '0);
    assign mem_go   = ((r_state == S_EXEC) && is_ldst && MEM_POW2) || mod_last;
    assign dm_addr  = (r_state == S_MOD) ? rem_nx : DM_AW'(op_b);

    assign dm_we = (r_state == S_CLEAR) || (mem_go && (r_op == OP_STORE));
    assign dm_wa = (r_state == S_CLEAR) ? r_clr_addr : dm_addr;
    assign dm_wd = (r_state == S_CLEAR) ? '0 : op_a;

    always_comb begin
        case (r_op)
            OP_ADD:  alu_val = op_a + op_b;
            OP_SUB:  alu_val = op_a - op_b;
            OP_AND:  alu_val = op_a & op_b;
            OP_OR:   alu_val = op_a | op_b;
            OP_CMP:  alu_val = WORD_BITS'(op_a == op_b);
            default: alu_val = '0;
        endcase
    end

    // Register writeback: ALU ops and move at execute, load on data return.
    always_comb begin
        rf_we = 1'b0;
        rf_wa = r_rc;
        rf_wd = alu_val;
        if (r_state == S_EXEC) begin
            if (r_op <= OP_CMP) begin
                rf_we = reg_ok(r_rc);
            end else if (r_op == OP_MOVE) begin
                rf_we = reg_ok(r_ra);
                rf_wa = r_ra;
                rf_wd = r_imm;
            end
        end else if (r_state == S_LOAD) begin
            rf_we = reg_ok(r_ra);
            rf_wa = r_ra;
            rf_wd = r_mem_rd;
        end
    end

    // Result selection and sequencing.
    always_comb begin
        n_state  = r_state;
        n_done   = 1'b0;
        res_word = '0;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == DM_AW'(MEM_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (is_ldst) begin
                    if (!MEM_POW2) begin
                        n_state = S_MOD;
                    end else if (r_op == OP_LOAD) begin
                        n_state = S_LOAD;
                    end else begin
                        n_state  = S_IDLE;
                        n_done   = 1'b1;
                        res_word = op_a;
                    end
                end else begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                    if (r_op <= OP_CMP) begin
                        res_word = reg_ok(r_rc) ? alu_val : '0;
                    end else if (r_op == OP_MOVE) begin
                        res_word = reg_ok(r_ra) ? r_imm : '0;
                    end else begin
                        res_word = op_a;
                    end
                end
            end
            S_MOD: begin
                if (mod_last) begin
                    if (r_op == OP_LOAD) begin
                        n_state = S_LOAD;
                    end else begin
                        n_state  = S_IDLE;
                        n_done   = 1'b1;
                        res_word = op_a;
                    end
                end
            end
            S_LOAD: begin
                n_state  = S_IDLE;
                n_done   = 1'b1;
                res_word = reg_ok(r_ra) ? r_mem_rd : '0;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign res_wide = 64'(res_word);
    assign n_result = res_wide[RESULT_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_done     <= 1'b0;
            r_rf_valid <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + DM_AW'(1);
            end
            if (rf_we) begin
                r_rf_valid[rf_idx(rf_wa)] <= 1'b1;
            end
        end
    end

    // Register file: two reads at accept, one write at writeback.
    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            rf[rf_idx(rf_wa)] <= rf_wd;
        end
        if (accept) begin
            r_rd_a <= rf[rf_idx(rd_idx_a)];
            r_rd_b <= rf[rf_idx(i_second_reg)];
        end
    end

    // Data memory: clearing sweep and stores write, loads read.
    always_ff @(posedge i_clk) begin
        if (dm_we) begin
            dmem[dm_wa] <= dm_wd;
        end
        if (mem_go) begin
            r_mem_rd <= dmem[dm_addr];
        end
    end

    // Hold the request and the zero flags of its operands, register the result and step the address reduction.
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (accept) begin
            r_op     <= i_operation;
            r_ra     <= i_first_reg;
            r_rc     <= i_dest_reg;
            r_imm    <= WORD_BITS'(i_immediate);
            r_a_zero <= !(reg_ok(rd_idx_a) && r_rf_valid[rf_idx(rd_idx_a)]);
            r_b_zero <= !(reg_ok(i_second_reg) && r_rf_valid[rf_idx(i_second_reg)]);
        end
        if ((r_state == S_EXEC) && is_ldst) begin
            r_rem     <= '0;
            r_div_src <= SRC_BITS'(op_b);
            r_mod_cnt <= CNT_W'(N_CHUNKS - 1);
            r_mod_ph  <= 1'b0;
        end else if (r_state == S_MOD) begin
            if (!r_mod_ph) begin
                r_quo    <= quo_wide[63:32];
                r_mod_ph <= 1'b1;
            end else begin
                r_rem     <= rem_nx;
                r_div_src <= r_div_src << CHUNK_BITS;
                r_mod_cnt <= r_mod_cnt - CNT_W'(1);
                r_mod_ph  <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/lsms_checker.sv
// Port-level checker for the load/store step unit and its bind.
module lsms_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done
);

    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> (busy && !o_done))
        else $error("busy low or result shown after reset");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_accept_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_done)
        else $error("result right after an accepted request");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without work in progress");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

endmodule

bind load_store_machine_step_unit lsms_checker u_lsms_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done)
);

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the load/store step unit: directed table, then random requests.
module tb_top;
    import lsms_pkg::*;

    // Default sizes of the block; the predictor below is built for exactly these.
    localparam int REG_COUNT = 32;
    localparam int MEM_WORDS = 1024;
    localparam int WORD_BITS = 32;
    localparam logic [31:0] ADDR_MASK = 32'h3FF;

    // The package names the defined opcodes only; name the rest here.
    localparam t_opcode OP_NOP        = 4'd8;
    localparam t_opcode OP_RSVD_FIRST = 4'd9;
    localparam t_opcode OP_RSVD_LAST  = 4'd15;

    localparam int CLK_PERIOD       = 12;
    localparam int RESET_CYCLES     = 12;
    localparam int DIRECTED_ROWS    = 25;
    localparam int RANDOM_PER_PHASE = 200;
    localparam int PHASE_COUNT      = 4;
    localparam int DRAIN_CYCLES     = 8;
    localparam int MAX_REPORTS      = 10;
    // Watchdog limit in ns; the slowest legal run, memory sweep included, ends well inside it.
    localparam int RUN_LIMIT_NS     = 2_000_000;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    t_opcode                     i_operation;
    t_reg_idx                    i_first_reg;
    t_reg_idx                    i_second_reg;
    t_reg_idx                    i_dest_reg;
    logic [IMM_BITS-1:0]         i_immediate;
    logic                        busy;
    logic                        o_done;
    logic [RESULT_BITS-1:0]      o_result_word;

    // One row of the directed table: the instruction and, where it is obvious,
    // the word it must return. Rows without a typed word use the predictor.
    typedef struct packed {
        t_opcode     op;
        t_reg_idx    ra;
        t_reg_idx    rb;
        t_reg_idx    rc;
        logic [31:0] imm;
        logic        typed;
        logic [31:0] want;
    } t_dir_row;

    t_dir_row    directed_rows [DIRECTED_ROWS];

    // Predictor state: architectural registers and data memory.
    logic [31:0] arch_regs [REG_COUNT];
    logic [31:0] arch_mem  [MEM_WORDS];

    // Result words awaited from the block, oldest first.
    logic [31:0] pending_results [$];
    logic [31:0] expected_word;

    int          sender_idle_pct;
    int          fail_count;
    int          n_requests;
    int          n_directed;
    int          n_loads;
    int          n_stores;
    int          n_checked;

    load_store_machine_step_unit #(
        .REG_COUNT (REG_COUNT),
        .MEM_WORDS (MEM_WORDS),
        .WORD_BITS (WORD_BITS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .i_operation   (i_operation),
        .i_first_reg   (i_first_reg),
        .i_second_reg  (i_second_reg),
        .i_dest_reg    (i_dest_reg),
        .i_immediate   (i_immediate),
        .busy          (busy),
        .o_done        (o_done),
        .o_result_word (o_result_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Register zero reads as zero no matter what was written.
    function automatic logic [31:0] read_reg(input t_reg_idx idx);
        return (idx == '0) ? 32'd0 : arch_regs[idx];
    endfunction

    // Drop writes to register zero.
    function automatic void write_reg(input t_reg_idx idx, input logic [31:0] value);
        if (idx != '0) begin
            arch_regs[idx] = value;
        end
    endfunction

    // Execute one instruction on the predictor state and return the word the
    // block must report for it.
    function automatic logic [31:0] execute_instruction(
        input t_opcode     op,
        input t_reg_idx    ra,
        input t_reg_idx    rb,
        input t_reg_idx    rc,
        input logic [31:0] imm
    );
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] addr;
        a    = read_reg(ra);
        b    = read_reg(rb);
        addr = b & ADDR_MASK;
        case (op)
            OP_ADD:   write_reg(rc, a + b);
            OP_SUB:   write_reg(rc, a - b);
            OP_AND:   write_reg(rc, a & b);
            OP_OR:    write_reg(rc, a | b);
            OP_CMP:   write_reg(rc, (a == b) ? 32'd1 : 32'd0);
            OP_LOAD:  write_reg(ra, arch_mem[addr]);
            OP_STORE: arch_mem[addr] = a;
            OP_MOVE:  write_reg(ra, imm);
            default:  ;
        endcase
        if (op == OP_LOAD || op == OP_MOVE) begin
            return read_reg(ra);
        end else if (op == OP_STORE) begin
            return arch_mem[addr];
        end else begin
            return read_reg(rc);
        end
    endfunction

    // Hand one request to the block. Entered and left just after a falling
    // edge. Idle cycles go in front at the current rate; start stays high
    // from one request to the next when there is no idle cycle between them.
    task automatic send_request(
        input t_opcode     op,
        input t_reg_idx    ra,
        input t_reg_idx    rb,
        input t_reg_idx    rc,
        input logic [31:0] imm,
        input logic        typed,
        input logic [31:0] want
    );
        logic [31:0] predicted;
        while ($urandom_range(99) < sender_idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start        = 1'b1;
        i_operation  = op;
        i_first_reg  = ra;
        i_second_reg = rb;
        i_dest_reg   = rc;
        i_immediate  = imm;
        // Hold the request until an edge finds the block free.
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        predicted = execute_instruction(op, ra, rb, rc, imm);
        pending_results.push_back(typed ? want : predicted);
        n_requests++;
        if (op == OP_LOAD) n_loads++;
        if (op == OP_STORE) n_stores++;
        @(negedge i_clk);
    endtask

    // Pick a register index, leaning on register zero now and then.
    function automatic t_reg_idx pick_reg();
        if ($urandom_range(99) < 10) begin
            return '0;
        end
        return t_reg_idx'($urandom_range(REG_COUNT - 1));
    endfunction

    // Immediates: full random words, words whose address bits land on a few
    // memory entries so loads and stores meet, and the corner values.
    function automatic logic [31:0] pick_immediate();
        logic [31:0] value;
        value = $urandom;
        case ($urandom_range(3))
            0: value[9:0] = 10'($urandom_range(15));
            1: begin
                case ($urandom_range(4))
                    0: value = 32'h0000_0000;
                    1: value = 32'hFFFF_FFFF;
                    2: value = 32'h8000_0000;
                    3: value = 32'h7FFF_FFFF;
                    default: value = 32'h0000_0001;
                endcase
            end
            default: ;
        endcase
        return value;
    endfunction

    // Opcode mix: ALU work the largest share, a fair share of memory traffic and moves,
    // and a little nop and reserved-code noise.
    function automatic t_opcode pick_opcode();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40) return t_opcode'($urandom_range(OP_CMP, OP_ADD));
        if (roll < 55) return OP_LOAD;
        if (roll < 70) return OP_STORE;
        if (roll < 88) return OP_MOVE;
        return t_opcode'($urandom_range(OP_RSVD_LAST, OP_NOP));
    endfunction

    // Check every strobed result against the oldest awaited word.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                if (fail_count < MAX_REPORTS) begin
                    $display("[%0t] unexpected result 0x%08h with nothing outstanding",
                             $realtime, o_result_word);
                end
                fail_count++;
            end else begin
                expected_word = pending_results.pop_front();
                n_checked++;
                if (o_result_word !== expected_word) begin
                    if (fail_count < MAX_REPORTS) begin
                        $display("[%0t] result_word mismatch: expected 0x%08h, got 0x%08h",
                                 $realtime, expected_word, o_result_word);
                    end
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end a hung run.
    initial begin
        #(RUN_LIMIT_NS);
        $display("[%0t] timeout with %0d results outstanding",
                 $realtime, pending_results.size());
        $display("load_store_machine_step_unit regression: fail");
        $finish;
    end

    initial begin
        int phase_idle [PHASE_COUNT];
        t_dir_row row;

        // Directed table. Typed words follow from reset contents, wraparound,
        // register zero, the address mask and the reserved codes.
        directed_rows = '{
            // nothing written yet: registers read zero
            '{OP_NOP,        5'd0,  5'd0,  5'd5,  32'h0,         1'b1, 32'h0},
            // memory cleared by the post-reset sweep
            '{OP_LOAD,       5'd3,  5'd31, 5'd0,  32'h0,         1'b1, 32'h0},
            '{OP_MOVE,       5'd1,  5'd0,  5'd0,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
            // register zero ignores a move
            '{OP_MOVE,       5'd0,  5'd0,  5'd0,  32'hDEAD_BEEF, 1'b1, 32'h0},
            '{OP_MOVE,       5'd2,  5'd0,  5'd0,  32'h1,         1'b1, 32'h1},
            // add wraps to zero
            '{OP_ADD,        5'd1,  5'd2,  5'd3,  32'h0,         1'b1, 32'h0},
            // sub wraps below zero
            '{OP_SUB,        5'd0,  5'd2,  5'd4,  32'h0,         1'b1, 32'hFFFF_FFFF},
            '{OP_AND,        5'd1,  5'd2,  5'd5,  32'h0,         1'b1, 32'h1},
            '{OP_OR,         5'd1,  5'd2,  5'd6,  32'h0,         1'b1, 32'hFFFF_FFFF},
            '{OP_CMP,        5'd1,  5'd1,  5'd7,  32'h0,         1'b1, 32'h1},
            '{OP_CMP,        5'd1,  5'd2,  5'd8,  32'h0,         1'b1, 32'h0},
            '{OP_MOVE,       5'd31, 5'd0,  5'd0,  32'h3FF,       1'b1, 32'h3FF},
            // top memory word
            '{OP_STORE,      5'd1,  5'd31, 5'd0,  32'h0,         1'b1, 32'hFFFF_FFFF},
            '{OP_LOAD,       5'd9,  5'd31, 5'd0,  32'h0,         1'b1, 32'hFFFF_FFFF},
            // address bits above the mask are dropped: 0x400 hits word 0
            '{OP_MOVE,       5'd10, 5'd0,  5'd0,  32'h400,       1'b1, 32'h400},
            '{OP_LOAD,       5'd11, 5'd10, 5'd0,  32'h0,         1'b1, 32'h0},
            '{OP_STORE,      5'd2,  5'd10, 5'd0,  32'h0,         1'b1, 32'h1},
            '{OP_LOAD,       5'd12, 5'd0,  5'd0,  32'h0,         1'b1, 32'h1},
            // load into register zero is dropped
            '{OP_LOAD,       5'd0,  5'd31, 5'd0,  32'h0,         1'b1, 32'h0},
            // reserved codes behave as nop and report rc
            '{OP_RSVD_LAST,  5'd0,  5'd0,  5'd1,  32'h0,         1'b1, 32'hFFFF_FFFF},
            '{OP_RSVD_FIRST, 5'd0,  5'd0,  5'd31, 32'h0,         1'b1, 32'h3FF},
            '{OP_MOVE,       5'd13, 5'd0,  5'd0,  32'hA5A5_F00F, 1'b0, 32'h0},
            '{OP_SUB,        5'd13, 5'd1,  5'd14, 32'h0,         1'b0, 32'h0},
            // store of register zero writes a zero word
            '{OP_STORE,      5'd0,  5'd2,  5'd0,  32'h0,         1'b1, 32'h0},
            // ALU write to register zero is dropped
            '{OP_ADD,        5'd13, 5'd14, 5'd0,  32'hFFFF_FFFF, 1'b1, 32'h0}
        };
        phase_idle = '{0, 56, 29, 0};

        fail_count      = 0;
        n_requests      = 0;
        n_loads         = 0;
        n_stores        = 0;
        n_checked       = 0;
        sender_idle_pct = 0;
        for (int i = 0; i < REG_COUNT; i++) arch_regs[i] = '0;
        for (int i = 0; i < MEM_WORDS; i++) arch_mem[i] = '0;

        // Drive every input from time zero and hold reset.
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_operation  = OP_NOP;
        i_first_reg  = '0;
        i_second_reg = '0;
        i_dest_reg   = '0;
        i_immediate  = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part, back to back.
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_request(row.op, row.ra, row.rb, row.rc, row.imm, row.typed, row.want);
        end
        n_directed = n_requests;

        // Random part, one idle rate per phase.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            sender_idle_pct = phase_idle[p];
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                send_request(pick_opcode(), pick_reg(), pick_reg(), pick_reg(),
                             pick_immediate(), 1'b0, 32'h0);
            end
        end
        start = 1'b0;

        // Drain: wait for every awaited word, then a few quiet cycles.
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pending_results.size() != 0) begin
            $display("%0d results never arrived", pending_results.size());
            fail_count++;
        end

        $display("ran %0d requests (%0d from the table), %0d loads and %0d stores,",
                 n_requests, n_directed, n_loads, n_stores);
        $display("over idle rates 0/56/29/0 percent; %0d results checked, %0d failures",
                 n_checked, fail_count);
        if (fail_count == 0) begin
            $display("load_store_machine_step_unit regression: pass");
        end else begin
            $display("load_store_machine_step_unit regression: fail");
        end
        $finish;
    end

endmodule
